@@ rtl/gids_pkg.sv @@
// ----------------------------------------------------------------------------
// gids_pkg: shared definitions for the greedy independent dominating set block
// Holds the default sizes, the fixed field widths, the operation codes and the node count reset value.
// ----------------------------------------------------------------------------
`default_nettype none

package gids_pkg;

    // Default sizes handed to the top level parameters.
    localparam int DEF_MAX_VERTICES = 64;
    localparam int DEF_DEGREE_BITS  = 10;

    // Fixed widths of the transaction fields.
    localparam int OP_BITS     = 2;
    localparam int VERTEX_BITS = 7;

    // Operation codes carried in the op field.
    localparam logic [OP_BITS-1:0] OP_ADD_EDGE = 2'd0;
    localparam logic [OP_BITS-1:0] OP_RUN      = 2'd1;
    localparam logic [OP_BITS-1:0] OP_CLEAR    = 2'd2;

    // Value of the node count register after reset.
    localparam logic [VERTEX_BITS-1:0] NODE_COUNT_RESET = 7'd64;

endpackage : gids_pkg

`default_nettype wire

@@ rtl/greedy_independent_dominating_set.sv @@
// ----------------------------------------------------------------------------
// greedy_independent_dominating_set: greedy maximal independent set by degree
// Stores a graph edge by edge and, on request, lists a maximal independent
// set chosen in order of falling vertex degree.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_stall    op, vertex_a, vertex_b
// out       output     out_valid / out_stall  member, set_size, last_member
// cfg       input      cfg_we                 cfg_data (node count)
//
// An add edge transaction does two read-modify-writes of the dual port RAM,
// one per end; a clear, an ignored edge or an empty run leaves the block
// idle. A run over n vertices has n rounds, each of which sweeps the RAM
// one word a cycle to rank the next vertex. Reset and clear drop the row
// valid bits, so unwritten rows read as zero. An output stall holds up the
// run only while a member waits on a full output register.
//
`default_nettype none

module greedy_independent_dominating_set
    import gids_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int DEGREE_BITS  = DEF_DEGREE_BITS
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   cfg_we,
    input  wire logic [VERTEX_BITS-1:0] cfg_data,

    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [OP_BITS-1:0]     op,
    input  wire logic [VERTEX_BITS-1:0] vertex_a,
    input  wire logic [VERTEX_BITS-1:0] vertex_b,

    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [VERTEX_BITS-1:0]      member,
    output logic [VERTEX_BITS-1:0]      set_size,
    output logic                        last_member
);

    // Width of a vertex index into the RAM and the bit vectors.
    localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    // Each RAM word holds a vertex's degree above its adjacency row.
    localparam int WORD_BITS = MAX_VERTICES + DEGREE_BITS;
    // Largest vertex count the 7-bit node count can ask for.
    localparam int VERTEX_CAP = (MAX_VERTICES < 127) ? MAX_VERTICES : 127;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ADD_A  = 3'd1;
    localparam logic [2:0] S_ADD_RB = 3'd2;
    localparam logic [2:0] S_ADD_B  = 3'd3;
    localparam logic [2:0] S_SCAN   = 3'd4;
    localparam logic [2:0] S_PICK   = 3'd5;
    localparam logic [2:0] S_EMIT   = 3'd6;
    localparam logic [2:0] S_FLUSH  = 3'd7;

    typedef logic [MAX_VERTICES-1:0] vset_t;
    typedef logic [DEGREE_BITS-1:0]  degree_t;

    logic [2:0]             state_reg, state_next;
    logic [VERTEX_BITS-1:0] node_count_reg;
    vset_t                  row_valid_reg, row_valid_next;
    vset_t                  visited_reg, visited_next;
    vset_t                  taken_reg, taken_next;
    logic [VW-1:0]          ia_reg, ia_next;
    logic [VW-1:0]          ib_reg, ib_next;
    logic [VERTEX_BITS-1:0] scan_reg, scan_next;
    logic [VERTEX_BITS-1:0] round_reg, round_next;
    logic [VERTEX_BITS-1:0] count_reg, count_next;
    logic                   rd_pend_reg, rd_pend_next;
    logic [VW-1:0]          rd_addr_reg;
    logic                   found_reg, found_next;
    logic [VW-1:0]          best_reg, best_next;
    degree_t                best_deg_reg, best_deg_next;
    vset_t                  best_row_reg, best_row_next;
    logic                   pend_valid_reg, pend_valid_next;
    logic [VERTEX_BITS-1:0] pend_member_reg, pend_member_next;
    logic [VERTEX_BITS-1:0] pend_size_reg, pend_size_next;
    logic                   out_valid_reg, out_valid_next;
    logic [VERTEX_BITS-1:0] member_reg, member_next;
    logic [VERTEX_BITS-1:0] set_size_reg, set_size_next;
    logic                   last_reg, last_next;

    // RAM ports.
    logic                   wr_en;
    logic [VW-1:0]          wr_addr;
    logic [WORD_BITS-1:0]   wr_data;
    logic [VW-1:0]          rd_addr;
    logic [WORD_BITS-1:0]   rd_data;

    // Derived values.
    logic [VERTEX_BITS-1:0] n_eff;
    logic                   a_ok, b_ok;
    logic [WORD_BITS-1:0]   word;
    vset_t                  word_row;
    degree_t                word_deg;
    degree_t                deg_inc;
    logic                   out_free;

    gids_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAX_VERTICES),
        .AW    (VW)
    ) u_adj_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // The node count is clamped to the number of vertices the RAM can store.
    assign n_eff = (int'(node_count_reg) > VERTEX_CAP) ? VERTEX_BITS'(VERTEX_CAP)
                                                      : node_count_reg;

    assign a_ok = (vertex_a != '0) && (vertex_a <= n_eff);
    assign b_ok = (vertex_b != '0) && (vertex_b <= n_eff);

    // A row that was never written since reset or a clear reads as zero.
    assign word     = row_valid_reg[rd_addr_reg] ? rd_data : '0;
    assign word_row = word[MAX_VERTICES-1:0];
    assign word_deg = word[WORD_BITS-1:MAX_VERTICES];
    assign deg_inc  = (word_deg == '1) ? word_deg : word_deg + degree_t'(1);

    // The output register can take a new result this cycle.
    assign out_free = !out_valid_reg || !out_stall;

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign member      = member_reg;
    assign set_size    = set_size_reg;
    assign last_member = last_reg;

    always_comb
    begin
        state_next       = state_reg;
        row_valid_next   = row_valid_reg;
        visited_next     = visited_reg;
        taken_next       = taken_reg;
        ia_next          = ia_reg;
        ib_next          = ib_reg;
        scan_next        = scan_reg;
        round_next       = round_reg;
        count_next       = count_reg;
        rd_pend_next     = 1'b0;
        found_next       = found_reg;
        best_next        = best_reg;
        best_deg_next    = best_deg_reg;
        best_row_next    = best_row_reg;
        pend_valid_next  = pend_valid_reg;
        pend_member_next = pend_member_reg;
        pend_size_next   = pend_size_reg;
        out_valid_next   = out_valid_reg && out_stall;
        member_next      = member_reg;
        set_size_next    = set_size_reg;
        last_next        = last_reg;
        wr_en            = 1'b0;
        wr_addr          = ia_reg;
        wr_data          = '0;
        rd_addr          = VW'(scan_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                // The first end's word is read in the cycle of acceptance.
                rd_addr = VW'(vertex_a - VERTEX_BITS'(1));
                if (in_valid)
                begin
                    unique case (op)
                        OP_ADD_EDGE:
                        begin
                            if (a_ok && b_ok)
                            begin
                                ia_next    = VW'(vertex_a - VERTEX_BITS'(1));
                                ib_next    = VW'(vertex_b - VERTEX_BITS'(1));
                                state_next = S_ADD_A;
                            end
                        end
                        OP_RUN:
                        begin
                            if (n_eff != '0)
                            begin
                                visited_next    = '0;
                                taken_next      = '0;
                                scan_next       = '0;
                                round_next      = '0;
                                count_next      = '0;
                                found_next      = 1'b0;
                                pend_valid_next = 1'b0;
                                state_next      = S_SCAN;
                            end
                        end
                        OP_CLEAR:
                        begin
                            row_valid_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_ADD_A:
            begin
                wr_en                   = 1'b1;
                wr_addr                 = ia_reg;
                wr_data                 = {deg_inc, word_row | (vset_t'(1) << ib_reg)};
                row_valid_next[ia_reg]  = 1'b1;
                state_next              = S_ADD_RB;
            end

            S_ADD_RB:
            begin
                // Read the second end after the first is written back, so a
                // self-loop counts twice.
                rd_addr    = ib_reg;
                state_next = S_ADD_B;
            end

            S_ADD_B:
            begin
                wr_en                   = 1'b1;
                wr_addr                 = ib_reg;
                wr_data                 = {deg_inc, word_row | (vset_t'(1) << ia_reg)};
                row_valid_next[ib_reg]  = 1'b1;
                state_next              = S_IDLE;
            end

            S_SCAN:
            begin
                // Compare the word read in the previous cycle; a strict
                // greater-than keeps ties on the lower index.
                if (rd_pend_reg && !taken_reg[rd_addr_reg] &&
                    (!found_reg || (word_deg > best_deg_reg)))
                begin
                    found_next    = 1'b1;
                    best_next     = rd_addr_reg;
                    best_deg_next = word_deg;
                    best_row_next = word_row;
                end
                if (scan_reg != n_eff)
                begin
                    rd_addr      = VW'(scan_reg);
                    scan_next    = scan_reg + VERTEX_BITS'(1);
                    rd_pend_next = 1'b1;
                end
                else
                begin
                    state_next = S_PICK;
                end
            end

            S_PICK:
            begin
                taken_next[best_reg] = 1'b1;
                round_next           = round_reg + VERTEX_BITS'(1);
                if (!visited_reg[best_reg])
                begin
                    visited_next = visited_reg | best_row_reg | (vset_t'(1) << best_reg);
                    state_next   = S_EMIT;
                end
                else if (round_next == n_eff)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    scan_next  = '0;
                    found_next = 1'b0;
                    state_next = S_SCAN;
                end
            end

            S_EMIT:
            begin
                // The previous member goes out only now that a later one
                // exists, so its last flag is known to be clear.
                if (!pend_valid_reg || out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        member_next    = pend_member_reg;
                        set_size_next  = pend_size_reg;
                        last_next      = 1'b0;
                    end
                    pend_valid_next  = 1'b1;
                    pend_member_next = VERTEX_BITS'(best_reg) + VERTEX_BITS'(1);
                    pend_size_next   = count_reg + VERTEX_BITS'(1);
                    count_next       = count_reg + VERTEX_BITS'(1);
                    if (round_reg == n_eff)
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        scan_next  = '0;
                        found_next = 1'b0;
                        state_next = S_SCAN;
                    end
                end
            end

            S_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    member_next     = pend_member_reg;
                    set_size_next   = pend_size_reg;
                    last_next       = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            node_count_reg <= NODE_COUNT_RESET;
            row_valid_reg  <= '0;
            rd_pend_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            row_valid_reg  <= row_valid_next;
            rd_pend_reg    <= rd_pend_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                node_count_reg <= cfg_data;
            end
        end
    end

    // Working registers and payload.
    always_ff @(posedge clk)
    begin
        visited_reg     <= visited_next;
        taken_reg       <= taken_next;
        ia_reg          <= ia_next;
        ib_reg          <= ib_next;
        scan_reg        <= scan_next;
        round_reg       <= round_next;
        count_reg       <= count_next;
        rd_addr_reg     <= rd_addr;
        found_reg       <= found_next;
        best_reg        <= best_next;
        best_deg_reg    <= best_deg_next;
        best_row_reg    <= best_row_next;
        pend_member_reg <= pend_member_next;
        pend_size_reg   <= pend_size_next;
        member_reg      <= member_next;
        set_size_reg    <= set_size_next;
        last_reg        <= last_next;
    end

    // Every round ranks exactly one vertex.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> ($countones(taken_reg) == int'(round_reg)))
        else $error("ranked vertex count does not match the round");

    // A vertex about to be emitted has just been marked visited.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> visited_reg[best_reg])
        else $error("emitted vertex not marked visited");

    // A held member never outlives its run.
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (state_reg != S_IDLE))
        else $error("pending member left behind after the run");

    // A result loaded into the output register has a size of at least one.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> (set_size_reg != '0))
        else $error("result with empty set size");

endmodule : greedy_independent_dominating_set

`default_nettype wire

@@ rtl/gids_ram.sv @@
// ----------------------------------------------------------------------------
// gids_ram: generic simple dual port RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module gids_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule : gids_ram

`default_nettype wire

@@ tb/tb_greedy_independent_dominating_set.sv @@
// ----------------------------------------------------------------------------
// tb_greedy_independent_dominating_set: self-checking bench for the greedy set
// Loads graphs edge by edge, starts greedy runs under several vertex counts
// and checks every emitted member against a behavioral predictor of the
// degree-ordered greedy selection, with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_greedy_independent_dominating_set;
    timeunit 1ns;
    timeprecision 1ps;
    import gids_pkg::*;

    localparam int MAXV        = DEF_MAX_VERTICES;
    localparam int DEG_BITS    = DEF_DEGREE_BITS;
    localparam int DEG_CEIL    = (1 << DEG_BITS) - 1;
    localparam int CYCLE_LIMIT = 4000000;

    // The package defines three operations; the fourth code must be ignored.
    localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;

    // One emitted member as the output channel presents it.
    typedef struct packed {
        logic [VERTEX_BITS-1:0] member;
        logic [VERTEX_BITS-1:0] set_size;
        logic                   last_member;
    } member_rec_t;

    // Clock, reset and every block input start at a known value.
    logic                   clk         = 1'b0;
    logic                   rst_n       = 1'b0;
    logic                   cfg_we      = 1'b0;
    logic [VERTEX_BITS-1:0] cfg_data    = '0;
    logic                   in_valid    = 1'b0;
    logic [OP_BITS-1:0]     op          = OP_ADD_EDGE;
    logic [VERTEX_BITS-1:0] vertex_a    = '0;
    logic [VERTEX_BITS-1:0] vertex_b    = '0;
    logic                   out_stall   = 1'b0;
    logic                   in_stall;
    logic                   out_valid;
    logic [VERTEX_BITS-1:0] member;
    logic [VERTEX_BITS-1:0] set_size;
    logic                   last_member;

    // Shadow copy of the graph store and the node count register.
    logic [MAXV-1:0]        adj_rows [MAXV];
    logic [DEG_BITS-1:0]    degree   [MAXV];
    logic [VERTEX_BITS-1:0] node_count_shadow;

    // Members that the predictor says are still to come, oldest first.
    member_rec_t            pending_members [$];
    member_rec_t            want;

    int send_idle_pct   = 0;
    int stall_pct       = 0;
    int fail_count      = 0;
    int members_checked = 0;
    int items_sent      = 0;
    int runs_sent       = 0;
    int cycle_count     = 0;

    greedy_independent_dominating_set u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .vertex_a    (vertex_a),
        .vertex_b    (vertex_b),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .member      (member),
        .set_size    (set_size),
        .last_member (last_member)
    );

    // 20 ns period: high for half, low for half.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Hard stop in case the block hangs or a handshake never completes.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[greedy_independent_dominating_set] ERROR");
            $finish;
        end
    end

    // The receiver holds off results at random; the rate is set per phase.
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // ------------------------------------------------------------------
    // Predictor of the block
    // ------------------------------------------------------------------

    // The block never looks past MAX_VERTICES, whatever the register says.
    function automatic int active_vertices();
        return (node_count_shadow > MAXV) ? MAXV : int'(node_count_shadow);
    endfunction

    function automatic void clear_graph_shadow();
        for (int v = 0; v < MAXV; v++)
        begin
            adj_rows[v] = '0;
            degree[v]   = '0;
        end
    endfunction

    // Degrees saturate instead of wrapping.
    function automatic void bump_degree(input int v);
        if (degree[v] < DEG_CEIL)
            degree[v] = degree[v] + 1'b1;
    endfunction

    // Greedy selection: rank the vertices by falling degree with ties to the
    // lower index, take every vertex not yet covered and cover its
    // neighbours. Each taken vertex becomes one expected member.
    function automatic void predict_greedy_run();
        int              n;
        int              best;
        int              taken_count;
        logic [MAXV-1:0] ranked;
        logic [MAXV-1:0] covered;
        member_rec_t     rec;
        member_rec_t     run_members [$];
        n           = active_vertices();
        ranked      = '0;
        covered     = '0;
        taken_count = 0;
        for (int r = 0; r < n; r++)
        begin
            best = -1;
            for (int v = 0; v < n; v++)
            begin
                if (!ranked[v] && (best < 0 || degree[v] > degree[best]))
                    best = v;
            end
            ranked[best] = 1'b1;
            if (!covered[best])
            begin
                covered       = covered | adj_rows[best];
                covered[best] = 1'b1;
                taken_count++;
                rec.member      = VERTEX_BITS'(best + 1);
                rec.set_size    = VERTEX_BITS'(taken_count);
                rec.last_member = 1'b0;
                run_members.insert(run_members.size(), rec);
            end
        end
        if (run_members.size() > 0)
            run_members[run_members.size() - 1].last_member = 1'b1;
        foreach (run_members[i])
            pending_members.insert(pending_members.size(), run_members[i]);
    endfunction

    // Applies one accepted transaction to the shadow state.
    function automatic void apply_item(input logic [OP_BITS-1:0] code,
                                       input logic [VERTEX_BITS-1:0] a,
                                       input logic [VERTEX_BITS-1:0] b);
        int n;
        n = active_vertices();
        case (code)
            OP_ADD_EDGE:
            begin
                // Edges that touch vertex 0 or a vertex past the count are dropped.
                if (a != 0 && b != 0 && a <= n && b <= n)
                begin
                    adj_rows[a - 1][b - 1] = 1'b1;
                    adj_rows[b - 1][a - 1] = 1'b1;
                    bump_degree(a - 1);
                    bump_degree(b - 1);
                end
            end
            OP_RUN:   predict_greedy_run();
            OP_CLEAR: clear_graph_shadow();
            default:  ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    // Outputs are sampled at the falling edge, where they are stable; a
    // result seen valid and not stalled here is taken at the next rising edge.
    always @(negedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_members.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected member %0d (set_size %0d, last %0b)",
                             member, set_size, last_member);
            end
            else
            begin
                want = pending_members.pop_front();
                members_checked++;
                if (member !== want.member || set_size !== want.set_size ||
                    last_member !== want.last_member)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("member mismatch: expected %0d/%0d/%0b, got %0d/%0d/%0b",
                                 want.member, want.set_size, want.last_member,
                                 member, set_size, last_member);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Sends one transaction. It is entered at a rising edge and returns at
    // the rising edge that accepted the transaction. Valid is only lowered
    // inside a random gap, so back-to-back transactions keep it high.
    task automatic send_item(input logic [OP_BITS-1:0] code,
                             input logic [VERTEX_BITS-1:0] a,
                             input logic [VERTEX_BITS-1:0] b);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op       <= code;
        vertex_a <= a;
        vertex_b <= b;
        @(negedge clk);
        while (in_stall)
            @(negedge clk);
        @(posedge clk);
        apply_item(code, a, b);
        items_sent++;
        if (code == OP_RUN)
            runs_sent++;
    endtask

    // Waits until every predicted member has arrived, then gives the block
    // time to finish work that yields no result, such as an edge update or
    // the tail of a run sweep.
    task automatic wait_until_idle();
        int n;
        in_valid <= 1'b0;
        while (pending_members.size() != 0)
            @(posedge clk);
        n = active_vertices();
        repeat (n * (n + 3) + 16)
            @(posedge clk);
    endtask

    // The register is only written with the block idle.
    task automatic write_node_count(input logic [VERTEX_BITS-1:0] value);
        wait_until_idle();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        node_count_shadow = value;
    endtask

    // A stretch of random traffic under one node count. Most transactions
    // are in-range edges and runs; the rest are clears, edges with arbitrary
    // vertex numbers and the unused operation. The stretch ends on a run so
    // that the graph built in it is always read out.
    task automatic random_segment(input int cfg_value, input int item_total);
        int                     n;
        int                     pick;
        logic [VERTEX_BITS-1:0] a;
        logic [VERTEX_BITS-1:0] b;
        write_node_count(VERTEX_BITS'(cfg_value));
        n = active_vertices();
        for (int i = 0; i < item_total; i++)
        begin
            pick = $urandom_range(0, 99);
            a    = VERTEX_BITS'($urandom_range(1, n));
            b    = VERTEX_BITS'($urandom_range(1, n));
            if (i == item_total - 1 || (pick >= 70 && pick < 79))
                send_item(OP_RUN, a, b);
            else if (pick < 70)
                send_item(OP_ADD_EDGE, a, b);
            else if (pick < 82)
                send_item(OP_CLEAR, a, b);
            else if (pick < 93)
                send_item(OP_ADD_EDGE, VERTEX_BITS'($urandom), VERTEX_BITS'($urandom));
            else
                send_item(OP_UNUSED, VERTEX_BITS'($urandom), VERTEX_BITS'($urandom));
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // With the reset count of 64: both extreme vertices, a self-loop, a
    // duplicate edge, edges with vertex 0 or past the count, the unused
    // operation, then a run, and a run on the cleared graph where every
    // vertex is isolated and all 64 come out.
    task automatic test_edge_extremes();
        send_item(OP_ADD_EDGE, 7'd1, 7'd64);
        send_item(OP_ADD_EDGE, 7'd64, 7'd64);
        send_item(OP_ADD_EDGE, 7'd64, 7'd1);
        send_item(OP_ADD_EDGE, 7'd1, 7'd2);
        send_item(OP_ADD_EDGE, 7'd0, 7'd5);
        send_item(OP_ADD_EDGE, 7'd5, 7'd0);
        send_item(OP_ADD_EDGE, 7'd65, 7'd3);
        send_item(OP_ADD_EDGE, 7'd3, 7'd127);
        send_item(OP_UNUSED, 7'd127, 7'd127);
        send_item(OP_RUN, 7'd0, 7'd0);
        send_item(OP_CLEAR, 7'd0, 7'd0);
        send_item(OP_RUN, 7'd0, 7'd0);
    endtask

    // An empty vertex range emits nothing and ignores every edge; a single
    // vertex emits itself; a count past the maximum is clamped.
    task automatic test_node_count_extremes();
        write_node_count(7'd0);
        send_item(OP_ADD_EDGE, 7'd1, 7'd1);
        send_item(OP_RUN, 7'd0, 7'd0);
        write_node_count(7'd1);
        send_item(OP_ADD_EDGE, 7'd1, 7'd1);
        send_item(OP_RUN, 7'd0, 7'd0);
        write_node_count(7'd127);
        send_item(OP_ADD_EDGE, 7'd64, 7'd63);
        send_item(OP_RUN, 7'd0, 7'd0);
        send_item(OP_CLEAR, 7'd0, 7'd0);
    endtask

    // Edges stored under a larger count stay in the store after the count
    // shrinks: they still cover neighbours but the vertices past the count
    // are never emitted, and they are back once the count grows again.
    task automatic test_stale_vertices();
        write_node_count(7'd8);
        send_item(OP_ADD_EDGE, 7'd7, 7'd8);
        send_item(OP_ADD_EDGE, 7'd2, 7'd8);
        send_item(OP_ADD_EDGE, 7'd2, 7'd3);
        write_node_count(7'd5);
        send_item(OP_ADD_EDGE, 7'd3, 7'd7);
        send_item(OP_RUN, 7'd0, 7'd0);
        write_node_count(7'd8);
        send_item(OP_RUN, 7'd0, 7'd0);
        send_item(OP_CLEAR, 7'd0, 7'd0);
    endtask

    // Self-loops add two to a degree and equal degrees go to the lower
    // index. Vertices 2 and 3 both reach degree 4, so vertex 2 comes first;
    // counting a self-loop once or breaking the tie upward puts 3 first.
    task automatic test_degree_order();
        write_node_count(7'd3);
        repeat (2)
            send_item(OP_ADD_EDGE, 7'd2, 7'd2);
        send_item(OP_ADD_EDGE, 7'd3, 7'd3);
        repeat (2)
            send_item(OP_ADD_EDGE, 7'd3, 7'd1);
        send_item(OP_RUN, 7'd0, 7'd0);
        send_item(OP_CLEAR, 7'd0, 7'd0);
        send_item(OP_RUN, 7'd0, 7'd0);
    endtask

    // Random traffic under one idling mix: first a small graph, then a
    // graph of the given count.
    task automatic test_random_traffic(input int idle_pct, input int hold_pct,
                                       input int wide_count);
        send_idle_pct = idle_pct;
        stall_pct     = hold_pct;
        random_segment($urandom_range(2, 12), 30);
        random_segment(wide_count, 28);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        node_count_shadow = NODE_COUNT_RESET;
        clear_graph_shadow();
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_edge_extremes();
        test_node_count_extremes();
        test_stale_vertices();
        test_degree_order();
        test_random_traffic(0, 0, 64);
        test_random_traffic(57, 0, 1);
        test_random_traffic(0, 57, 127);
        test_random_traffic(6, 6, $urandom_range(20, 40));

        wait_until_idle();

        $display("Sent %0d transactions including %0d greedy runs; checked %0d members",
                 items_sent, runs_sent, members_checked);
        $display("under vertex counts from 0 to the clamp and four idling mixes.");
        if (fail_count == 0 && pending_members.size() == 0)
            $display("[greedy_independent_dominating_set] OK");
        else
            $display("[greedy_independent_dominating_set] ERROR");
        $finish;
    end

endmodule

@@ greedy_independent_dominating_set.f @@
rtl/gids_pkg.sv
rtl/gids_ram.sv
rtl/greedy_independent_dominating_set.sv
tb/tb_greedy_independent_dominating_set.sv
